### rtl/core/hq4x_pkg.sv
// hq4x_pkg: shared types, constants and rule functions for the hq4x upscaler.
// Depends on nothing; used by every module under rtl/core.
`default_nettype none
package hq4x_pkg;

    localparam int PIX_W   = 24;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DEF_FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LUMA_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_U_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_THR    = 2'd2;

    localparam logic [THR_W-1:0] RST_LUMA_THR = 8'd48;
    localparam logic [THR_W-1:0] RST_U_THR    = 8'd7;
    localparam logic [THR_W-1:0] RST_V_THR    = 8'd6;

    // Blend selector: which window pixel (w0 corner, w1 above, w3 left, w4 center)
    localparam logic [1:0] SRC_W4 = 2'd0;
    localparam logic [1:0] SRC_W3 = 2'd1;
    localparam logic [1:0] SRC_W1 = 2'd2;
    localparam logic [1:0] SRC_W0 = 2'd3;

    // One blend term: source and weight in eighths
    typedef struct packed {
        logic [1:0] src;
        logic [3:0] wt;
    } term_t;

    typedef struct packed {
        term_t a;
        term_t b;
        term_t c;
    } blend_t;

    // Four quadrant window pixels plus the four blend recipes of that quadrant
    typedef struct packed {
        logic [PIX_W-1:0] w0;
        logic [PIX_W-1:0] w1;
        logic [PIX_W-1:0] w3;
        logic [PIX_W-1:0] w4;
        blend_t [3:0]     rule;
    } quad_t;

    typedef struct packed {
        quad_t [3:0] quad;
    } job_t;

    typedef struct packed {
        logic [THR_W-1:0] y;
        logic [THR_W-1:0] u;
        logic [THR_W-1:0] v;
    } thr_t;

    function automatic logic differ(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input thr_t t);
        logic [7:0] dy, du, dv;
        begin
            dy = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
            du = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
            dv = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
            differ = (dy > t.y) || (du > t.u) || (dv > t.v);
        end
    endfunction

    function automatic logic pt(input logic [7:0] p, input logic [7:0] m, input logic [7:0] r);
        pt = ((p & m) == r);
    endfunction

    function automatic blend_t mk(input logic [1:0] sa, input logic [3:0] wa,
                                  input logic [1:0] sb, input logic [3:0] wb,
                                  input logic [1:0] sc, input logic [3:0] wc);
        blend_t b;
        begin
            b.a.src = sa; b.a.wt = wa;
            b.b.src = sb; b.b.wt = wb;
            b.c.src = sc; b.c.wt = wc;
            mk = b;
        end
    endfunction

    // Top-left hq4x rule chains: returns recipes for corner, horizontal, vertical, diagonal
    function automatic logic [4*$bits(blend_t)-1:0] rules(input logic [7:0] p,
                                                          input logic d15,
                                                          input logic d73,
                                                          input logic d31);
        logic c00, c01, c02, c03, c04, c05, c06, c07, c08, c09, c10, c11, c12, c13, c14, c15;
        blend_t q0, q1, q2, q3, ctr;
        begin
            ctr = mk(SRC_W4, 4'd8, SRC_W4, 4'd0, SRC_W4, 4'd0);
            c00 = (pt(p,8'hbf,8'h37) || pt(p,8'hdb,8'h13)) && d15;
            c01 = (pt(p,8'hdb,8'h49) || pt(p,8'hef,8'h6d)) && d73;
            c02 = (pt(p,8'h6f,8'h2a) || pt(p,8'h5b,8'h0a) || pt(p,8'hbf,8'h3a) ||
                   pt(p,8'hdf,8'h5a) || pt(p,8'h9f,8'h8a) || pt(p,8'hcf,8'h8a) ||
                   pt(p,8'hef,8'h4e) || pt(p,8'h3f,8'h0e) || pt(p,8'hfb,8'h5a) ||
                   pt(p,8'hbb,8'h8a) || pt(p,8'h7f,8'h5a) || pt(p,8'haf,8'h8a) ||
                   pt(p,8'heb,8'h8a)) && d31;
            c03 = pt(p,8'hdb,8'h49) || pt(p,8'hef,8'h6d);
            c04 = pt(p,8'hbf,8'h37) || pt(p,8'hdb,8'h13);
            c05 = pt(p,8'h1b,8'h03) || pt(p,8'h4f,8'h43) || pt(p,8'h8b,8'h83) ||
                  pt(p,8'h6b,8'h43);
            c06 = pt(p,8'h4b,8'h09) || pt(p,8'h8b,8'h89) || pt(p,8'h1f,8'h19) ||
                  pt(p,8'h3b,8'h19);
            c07 = pt(p,8'h0b,8'h08) || pt(p,8'hf9,8'h68) || pt(p,8'hf3,8'h62) ||
                  pt(p,8'h6d,8'h6c) || pt(p,8'h67,8'h66) || pt(p,8'h3d,8'h3c) ||
                  pt(p,8'h37,8'h36) || pt(p,8'hf9,8'hf8) || pt(p,8'hdd,8'hdc) ||
                  pt(p,8'hf3,8'hf2) || pt(p,8'hd7,8'hd6) || pt(p,8'hdd,8'h1c) ||
                  pt(p,8'hd7,8'h16) || pt(p,8'h0b,8'h02);
            c08 = (pt(p,8'h0f,8'h0b) || pt(p,8'h2b,8'h0b) || pt(p,8'hfe,8'h4a) ||
                   pt(p,8'hfe,8'h1a)) && d31;
            c09 = pt(p,8'h2f,8'h2f);
            c10 = pt(p,8'h0a,8'h00);
            c11 = pt(p,8'h0b,8'h09);
            c12 = pt(p,8'h7e,8'h2a) || pt(p,8'hef,8'hab);
            c13 = pt(p,8'hbf,8'h8f) || pt(p,8'h7e,8'h0e);
            c14 = pt(p,8'h4f,8'h4b) || pt(p,8'h9f,8'h1b) || pt(p,8'h2f,8'h0b) ||
                  pt(p,8'hbe,8'h0a) || pt(p,8'hee,8'h0a) || pt(p,8'h7e,8'h0a) ||
                  pt(p,8'heb,8'h4b) || pt(p,8'h3b,8'h1b);
            c15 = pt(p,8'h0b,8'h03);

            if (c00) q0 = mk(SRC_W4,5, SRC_W3,3, SRC_W4,0);
            else if (c01) q0 = mk(SRC_W4,5, SRC_W1,3, SRC_W4,0);
            else if ((pt(p,8'h0b,8'h0b) || pt(p,8'hfe,8'h4a) || pt(p,8'hfe,8'h1a)) && d31)
                q0 = ctr;
            else if (c02) q0 = mk(SRC_W4,5, SRC_W0,3, SRC_W4,0);
            else if (c03) q0 = mk(SRC_W4,6, SRC_W3,2, SRC_W4,0);
            else if (c04) q0 = mk(SRC_W4,6, SRC_W1,2, SRC_W4,0);
            else if (c05) q0 = mk(SRC_W4,5, SRC_W3,3, SRC_W4,0);
            else if (c06) q0 = mk(SRC_W4,5, SRC_W1,3, SRC_W4,0);
            else if (pt(p,8'h0f,8'h0b) || pt(p,8'h5e,8'h0a) || pt(p,8'h2b,8'h0b) ||
                     pt(p,8'hbe,8'h0a) || pt(p,8'h7a,8'h0a) || pt(p,8'hee,8'h0a))
                q0 = mk(SRC_W1,4, SRC_W3,4, SRC_W4,0);
            else if (c07) q0 = mk(SRC_W4,5, SRC_W0,3, SRC_W4,0);
            else q0 = mk(SRC_W4,4, SRC_W1,2, SRC_W3,2);

            if (c00) q1 = mk(SRC_W4,7, SRC_W3,1, SRC_W4,0);
            else if (c08) q1 = ctr;
            else if (c02) q1 = mk(SRC_W4,6, SRC_W0,2, SRC_W4,0);
            else if (c09) q1 = ctr;
            else if (c10) q1 = mk(SRC_W4,5, SRC_W1,2, SRC_W3,1);
            else if (pt(p,8'h0b,8'h08)) q1 = mk(SRC_W4,5, SRC_W1,2, SRC_W0,1);
            else if (c11) q1 = mk(SRC_W4,5, SRC_W1,3, SRC_W4,0);
            else if (c04) q1 = mk(SRC_W1,6, SRC_W4,2, SRC_W4,0);
            else if (c12) q1 = mk(SRC_W1,4, SRC_W4,2, SRC_W3,2);
            else if (c13) q1 = mk(SRC_W1,5, SRC_W3,3, SRC_W4,0);
            else if (c05) q1 = mk(SRC_W4,7, SRC_W3,1, SRC_W4,0);
            else if (pt(p,8'hf3,8'h62) || pt(p,8'h67,8'h66) || pt(p,8'h37,8'h36) ||
                     pt(p,8'hf3,8'hf2) || pt(p,8'hd7,8'hd6) || pt(p,8'hd7,8'h16) ||
                     pt(p,8'h0b,8'h02))
                q1 = mk(SRC_W4,6, SRC_W0,2, SRC_W4,0);
            else if (c14) q1 = mk(SRC_W1,4, SRC_W4,4, SRC_W4,0);
            else q1 = mk(SRC_W4,6, SRC_W1,2, SRC_W4,0);

            if (c01) q2 = mk(SRC_W4,7, SRC_W1,1, SRC_W4,0);
            else if (c08) q2 = ctr;
            else if (c02) q2 = mk(SRC_W4,6, SRC_W0,2, SRC_W4,0);
            else if (c09) q2 = ctr;
            else if (c10) q2 = mk(SRC_W4,5, SRC_W3,2, SRC_W1,1);
            else if (pt(p,8'h0b,8'h02)) q2 = mk(SRC_W4,5, SRC_W3,2, SRC_W0,1);
            else if (c15) q2 = mk(SRC_W4,5, SRC_W3,3, SRC_W4,0);
            else if (c03) q2 = mk(SRC_W3,6, SRC_W4,2, SRC_W4,0);
            else if (c13) q2 = mk(SRC_W3,4, SRC_W4,2, SRC_W1,2);
            else if (c12) q2 = mk(SRC_W3,5, SRC_W1,3, SRC_W4,0);
            else if (c06) q2 = mk(SRC_W4,7, SRC_W1,1, SRC_W4,0);
            else if (pt(p,8'h0b,8'h08) || pt(p,8'hf9,8'h68) || pt(p,8'h6d,8'h6c) ||
                     pt(p,8'h3d,8'h3c) || pt(p,8'hf9,8'hf8) || pt(p,8'hdd,8'hdc) ||
                     pt(p,8'hdd,8'h1c))
                q2 = mk(SRC_W4,6, SRC_W0,2, SRC_W4,0);
            else if (c14) q2 = mk(SRC_W3,4, SRC_W4,4, SRC_W4,0);
            else q2 = mk(SRC_W4,6, SRC_W3,2, SRC_W4,0);

            if ((pt(p,8'h7f,8'h2b) || pt(p,8'hef,8'hab) || pt(p,8'hbf,8'h8f) ||
                 pt(p,8'h7f,8'h0f)) && d31)
                q3 = ctr;
            else if (c02) q3 = mk(SRC_W4,7, SRC_W0,1, SRC_W4,0);
            else if (c15) q3 = mk(SRC_W4,7, SRC_W3,1, SRC_W4,0);
            else if (c11) q3 = mk(SRC_W4,7, SRC_W1,1, SRC_W4,0);
            else if (pt(p,8'h0a,8'h00) || c12 || c13) q3 = mk(SRC_W4,6, SRC_W3,1, SRC_W1,1);
            else if (c07) q3 = mk(SRC_W4,7, SRC_W0,1, SRC_W4,0);
            else q3 = ctr;

            rules = {q3, q2, q1, q0};
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/hq4x_classify.sv
// hq4x_classify: front end; registers a window, builds difference patterns and
// picks blend recipes for all four quadrants. Uses hq4x_pkg.
`default_nettype none
module hq4x_classify (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hq4x_pkg::PIX_W-1:0]  win [9],
    input  wire hq4x_pkg::thr_t              thr,
    output logic                             job_valid,
    input  wire logic                        job_ready,
    output hq4x_pkg::job_t                   job
);

    logic                       full_reg;
    logic [hq4x_pkg::PIX_W-1:0] win_reg [9];
    hq4x_pkg::job_t             job_c;

    // Mirror order per quadrant: top-left, top-right, bottom-left, bottom-right
    localparam logic [3:0] MIR [4][9] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8},
        '{4'd2,4'd1,4'd0,4'd5,4'd4,4'd3,4'd8,4'd7,4'd6},
        '{4'd6,4'd7,4'd8,4'd3,4'd4,4'd5,4'd0,4'd1,4'd2},
        '{4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0}
    };
    localparam logic [3:0] NB [8] = '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd6,4'd7,4'd8};

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            win_reg <= win;
        end
    end

    always_comb
    begin
        logic [hq4x_pkg::PIX_W-1:0] mw [9];
        logic [7:0] pat;
        job_c = '0;
        for (int m = 0; m < 4; m++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                mw[i] = win_reg[MIR[m][i]];
            end
            for (int i = 0; i < 8; i++)
            begin
                pat[i] = hq4x_pkg::differ(mw[4], mw[NB[i]], thr);
            end
            job_c.quad[m].w0   = mw[0];
            job_c.quad[m].w1   = mw[1];
            job_c.quad[m].w3   = mw[3];
            job_c.quad[m].w4   = mw[4];
            job_c.quad[m].rule = hq4x_pkg::rules(pat,
                hq4x_pkg::differ(mw[1], mw[5], thr),
                hq4x_pkg::differ(mw[7], mw[3], thr),
                hq4x_pkg::differ(mw[3], mw[1], thr));
        end
    end

endmodule
`default_nettype wire

### rtl/core/hq4x_queue.sv
// hq4x_queue: small register FIFO of classified jobs between front and back.
// Uses hq4x_pkg for the job type.
`default_nettype none
module hq4x_queue #(
    parameter int DEPTH = hq4x_pkg::DEF_FIFO_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire hq4x_pkg::job_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output hq4x_pkg::job_t      rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hq4x_pkg::job_t      mem_reg [DEPTH];
    logic [AW-1:0]       wp_reg, rp_reg;
    logic [AW:0]         cnt_reg;
    logic                push, pop;

    assign wr_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/hq4x_blend.sv
// hq4x_blend: back end; walks the 16 output pixels of a job, blends one pixel
// per cycle in eighths unless the output stalls, and holds it in an output register. Uses hq4x_pkg.
`default_nettype none
module hq4x_blend (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire hq4x_pkg::job_t job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_luma,
    output logic [7:0]          out_u,
    output logic [7:0]          out_v,
    output logic [1:0]          sub_row,
    output logic [1:0]          sub_col,
    output logic                last
);

    logic [3:0]  k_reg;
    logic        ov_reg;
    logic [23:0] pix_reg;
    logic [3:0]  kout_reg;
    logic        load;
    logic [1:0]  quad, slot;
    hq4x_pkg::quad_t  q;
    hq4x_pkg::blend_t b;
    logic [23:0] pix_c;

    assign load      = job_valid && (!ov_reg || out_ready);
    assign job_ready = load && (k_reg == 4'd15);

    // Quadrant from the row/col high halves; slot 0 corner, 1 horizontal, 2 vertical, 3 diagonal
    always_comb
    begin
        logic r, c;
        quad = {k_reg[3], k_reg[1]};
        r = k_reg[3] ? !k_reg[2] : k_reg[2];
        c = k_reg[1] ? !k_reg[0] : k_reg[0];
        slot = {r, c};
        q = job.quad[quad];
        b = q.rule[slot];
    end

    function automatic logic [23:0] pick(input hq4x_pkg::quad_t qq, input logic [1:0] s);
        case (s)
            hq4x_pkg::SRC_W4: pick = qq.w4;
            hq4x_pkg::SRC_W3: pick = qq.w3;
            hq4x_pkg::SRC_W1: pick = qq.w1;
            hq4x_pkg::SRC_W0: pick = qq.w0;
            default:          pick = qq.w4;
        endcase
    endfunction

    always_comb
    begin
        logic [23:0] pa, pb, pc;
        logic [11:0] sum;
        pa = pick(q, b.a.src);
        pb = pick(q, b.b.src);
        pc = pick(q, b.c.src);
        for (int s = 0; s < 3; s++)
        begin
            sum = 12'(pa[s*8 +: 8]) * 12'(b.a.wt) + 12'(pb[s*8 +: 8]) * 12'(b.b.wt)
                + 12'(pc[s*8 +: 8]) * 12'(b.c.wt);
            pix_c[s*8 +: 8] = sum[10:3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix_c;
            kout_reg <= k_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_luma  = pix_reg[23:16];
    assign out_u     = pix_reg[15:8];
    assign out_v     = pix_reg[7:0];
    assign sub_row   = kout_reg[3:2];
    assign sub_col   = kout_reg[1:0];
    assign last      = (kout_reg == 4'd15);

endmodule
`default_nettype wire

### rtl/core/hq4x_pixel_upscaler.sv
// hq4x_pixel_upscaler: top level of the hq4x 3x3-to-4x4 upscaler.
// Instantiates hq4x_classify, hq4x_queue and hq4x_blend; uses hq4x_pkg.
//
// Channel   Direction  Handshake             Beat contents
// input     in         in_valid/in_ready     nine packed YUV window pixels
// result    out        out_valid/out_ready   one output pixel, position, last
// config    in         cfg_we                cfg_index, cfg_data (thresholds)
//
// Each window beat yields 16 result beats, one per cycle while out_ready is high;
// the result port of the blend stage sets the rate at which windows are taken.
// The classify stage registers a window and resolves all four quadrants
// combinationally; a job queue lets it take further windows while the blend stage drains.
// Reset clears control state and loads the standard thresholds (48, 7, 6).
// Out-of-range register indexes are dropped.
`default_nettype none
module hq4x_pixel_upscaler #(
    parameter int FIFO_DEPTH = hq4x_pkg::DEF_FIFO_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [hq4x_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hq4x_pkg::THR_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [23:0]                         top_left_pixel,
    input  wire logic [23:0]                         top_pixel,
    input  wire logic [23:0]                         top_right_pixel,
    input  wire logic [23:0]                         left_pixel,
    input  wire logic [23:0]                         center_pixel,
    input  wire logic [23:0]                         right_pixel,
    input  wire logic [23:0]                         bottom_left_pixel,
    input  wire logic [23:0]                         bottom_pixel,
    input  wire logic [23:0]                         bottom_right_pixel,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [7:0]                               out_luma,
    output logic [7:0]                               out_u,
    output logic [7:0]                               out_v,
    output logic [1:0]                               sub_row,
    output logic [1:0]                               sub_col,
    output logic                                     last
);

    hq4x_pkg::thr_t  thr_reg;
    logic [23:0]     win [9];
    logic            cj_valid, cj_ready, qj_valid, qj_ready;
    hq4x_pkg::job_t  cj, qj;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.y <= hq4x_pkg::RST_LUMA_THR;
            thr_reg.u <= hq4x_pkg::RST_U_THR;
            thr_reg.v <= hq4x_pkg::RST_V_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hq4x_pkg::REG_LUMA_THR: thr_reg.y <= cfg_data;
                hq4x_pkg::REG_U_THR:    thr_reg.u <= cfg_data;
                hq4x_pkg::REG_V_THR:    thr_reg.v <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign win[0] = top_left_pixel;
    assign win[1] = top_pixel;
    assign win[2] = top_right_pixel;
    assign win[3] = left_pixel;
    assign win[4] = center_pixel;
    assign win[5] = right_pixel;
    assign win[6] = bottom_left_pixel;
    assign win[7] = bottom_pixel;
    assign win[8] = bottom_right_pixel;

    hq4x_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .win       (win),
        .thr       (thr_reg),
        .job_valid (cj_valid),
        .job_ready (cj_ready),
        .job       (cj)
    );

    hq4x_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cj_valid),
        .wr_ready (cj_ready),
        .wr_data  (cj),
        .rd_valid (qj_valid),
        .rd_ready (qj_ready),
        .rd_data  (qj)
    );

    hq4x_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qj_valid),
        .job_ready (qj_ready),
        .job       (qj),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_luma  (out_luma),
        .out_u     (out_u),
        .out_v     (out_v),
        .sub_row   (sub_row),
        .sub_col   (sub_col),
        .last      (last)
    );

endmodule
`default_nettype wire

### bench/tb_hq4x_pixel_upscaler.sv
// tb_hq4x_pixel_upscaler: self-checking bench for the hq4x 3x3-to-4x4 upscaler.
// Depends on hq4x_pkg (register indexes, widths) and the hq4x_pixel_upscaler RTL.
// A behavioral model of the blend rules predicts every output pixel, checked in order.
`default_nettype none
module tb_hq4x_pixel_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    // Index past the last threshold register
    localparam logic [hq4x_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Threshold settings for the random phases: luma, U, V
    localparam logic [7:0] THR_SET [5][3] = '{
        '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd10, 8'd3, 8'd200},
        '{8'd128, 8'd64, 8'd1}, '{8'd48, 8'd7, 8'd6}};

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic [1:0] row;
        logic [1:0] col;
        logic       lst;
    } pixel_beat_t;

    typedef logic [23:0] window_t [9];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hq4x_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hq4x_pkg::THR_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [23:0] win_pix [9];
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_luma, out_u, out_v;
    logic [1:0] sub_row, sub_col;
    logic last;

    always #4 clk = ~clk;

    hq4x_pixel_upscaler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .top_left_pixel(win_pix[0]), .top_pixel(win_pix[1]),
        .top_right_pixel(win_pix[2]), .left_pixel(win_pix[3]),
        .center_pixel(win_pix[4]), .right_pixel(win_pix[5]),
        .bottom_left_pixel(win_pix[6]), .bottom_pixel(win_pix[7]),
        .bottom_right_pixel(win_pix[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_luma(out_luma), .out_u(out_u), .out_v(out_v),
        .sub_row(sub_row), .sub_col(sub_col), .last(last)
    );

    initial
    begin
        for (int i = 0; i < 9; i++)
            win_pix[i] = '0;
    end

    // Local copy of the thresholds, updated with every register write
    logic [7:0] thr_y = hq4x_pkg::RST_LUMA_THR;
    logic [7:0] thr_u = hq4x_pkg::RST_U_THR;
    logic [7:0] thr_v = hq4x_pkg::RST_V_THR;

    pixel_beat_t pending_pixels [$];
    bit failed = 1'b0;
    bit drain_idle = 1'b0;   // set for the final stretch: no idling anywhere
    int long_hold = 0;       // receiver hold-off, counted down by the receiver
    int quiet_cycles = 0;

    function automatic bit yuv_differ(logic [23:0] a, logic [23:0] b);
        int dy, du, dv;
        begin
            dy = int'(a[23:16]) - int'(b[23:16]);
            du = int'(a[15:8]) - int'(b[15:8]);
            dv = int'(a[7:0]) - int'(b[7:0]);
            if (dy < 0) dy = -dy;
            if (du < 0) du = -du;
            if (dv < 0) dv = -dv;
            return dy > thr_y || du > thr_u || dv > thr_v;
        end
    endfunction

    // Weighted blend in eighths, floored per component
    function automatic logic [23:0] blend8(logic [23:0] a, int wa, logic [23:0] b, int wb,
                                           logic [23:0] c, int wc);
        logic [23:0] res;
        int s;
        begin
            for (s = 0; s < 24; s += 8)
                res[s +: 8] = 8'((int'(a[s +: 8]) * wa + int'(b[s +: 8]) * wb +
                                  int'(c[s +: 8]) * wc) >> 3);
            return res;
        end
    endfunction

    // Top-left quadrant rules: q[0] corner, q[1] horizontal, q[2] vertical, q[3] diagonal
    function automatic void corner_rules(input window_t w, input logic [7:0] p,
                                         output logic [23:0] q [4]);
        logic [23:0] w0, w1, w3, w4;
        bit d15, d73, d31;
        bit c00, c01, c02, c03, c04, c05, c06, c07, c08, c09, c10, c11, c12, c13, c14, c15;
        begin
            w0 = w[0]; w1 = w[1]; w3 = w[3]; w4 = w[4];
            d15 = yuv_differ(w[1], w[5]);
            d73 = yuv_differ(w[7], w[3]);
            d31 = yuv_differ(w[3], w[1]);
            c03 = (p & 8'hdb) == 8'h49 || (p & 8'hef) == 8'h6d;
            c04 = (p & 8'hbf) == 8'h37 || (p & 8'hdb) == 8'h13;
            c00 = c04 && d15;
            c01 = c03 && d73;
            c02 = ((p & 8'h6f) == 8'h2a || (p & 8'h5b) == 8'h0a || (p & 8'hbf) == 8'h3a ||
                   (p & 8'hdf) == 8'h5a || (p & 8'h9f) == 8'h8a || (p & 8'hcf) == 8'h8a ||
                   (p & 8'hef) == 8'h4e || (p & 8'h3f) == 8'h0e || (p & 8'hfb) == 8'h5a ||
                   (p & 8'hbb) == 8'h8a || (p & 8'h7f) == 8'h5a || (p & 8'haf) == 8'h8a ||
                   (p & 8'heb) == 8'h8a) && d31;
            c05 = (p & 8'h1b) == 8'h03 || (p & 8'h4f) == 8'h43 || (p & 8'h8b) == 8'h83 ||
                  (p & 8'h6b) == 8'h43;
            c06 = (p & 8'h4b) == 8'h09 || (p & 8'h8b) == 8'h89 || (p & 8'h1f) == 8'h19 ||
                  (p & 8'h3b) == 8'h19;
            c07 = (p & 8'h0b) == 8'h08 || (p & 8'hf9) == 8'h68 || (p & 8'hf3) == 8'h62 ||
                  (p & 8'h6d) == 8'h6c || (p & 8'h67) == 8'h66 || (p & 8'h3d) == 8'h3c ||
                  (p & 8'h37) == 8'h36 || (p & 8'hf9) == 8'hf8 || (p & 8'hdd) == 8'hdc ||
                  (p & 8'hf3) == 8'hf2 || (p & 8'hd7) == 8'hd6 || (p & 8'hdd) == 8'h1c ||
                  (p & 8'hd7) == 8'h16 || (p & 8'h0b) == 8'h02;
            c08 = ((p & 8'h0f) == 8'h0b || (p & 8'h2b) == 8'h0b || (p & 8'hfe) == 8'h4a ||
                   (p & 8'hfe) == 8'h1a) && d31;
            c09 = (p & 8'h2f) == 8'h2f;
            c10 = (p & 8'h0a) == 8'h00;
            c11 = (p & 8'h0b) == 8'h09;
            c12 = (p & 8'h7e) == 8'h2a || (p & 8'hef) == 8'hab;
            c13 = (p & 8'hbf) == 8'h8f || (p & 8'h7e) == 8'h0e;
            c14 = (p & 8'h4f) == 8'h4b || (p & 8'h9f) == 8'h1b || (p & 8'h2f) == 8'h0b ||
                  (p & 8'hbe) == 8'h0a || (p & 8'hee) == 8'h0a || (p & 8'h7e) == 8'h0a ||
                  (p & 8'heb) == 8'h4b || (p & 8'h3b) == 8'h1b;
            c15 = (p & 8'h0b) == 8'h03;

            if (c00) q[0] = blend8(w4, 5, w3, 3, 0, 0);
            else if (c01) q[0] = blend8(w4, 5, w1, 3, 0, 0);
            else if (((p & 8'h0b) == 8'h0b || (p & 8'hfe) == 8'h4a ||
                      (p & 8'hfe) == 8'h1a) && d31) q[0] = w4;
            else if (c02) q[0] = blend8(w4, 5, w0, 3, 0, 0);
            else if (c03) q[0] = blend8(w4, 6, w3, 2, 0, 0);
            else if (c04) q[0] = blend8(w4, 6, w1, 2, 0, 0);
            else if (c05) q[0] = blend8(w4, 5, w3, 3, 0, 0);
            else if (c06) q[0] = blend8(w4, 5, w1, 3, 0, 0);
            else if ((p & 8'h0f) == 8'h0b || (p & 8'h5e) == 8'h0a || (p & 8'h2b) == 8'h0b ||
                     (p & 8'hbe) == 8'h0a || (p & 8'h7a) == 8'h0a || (p & 8'hee) == 8'h0a)
                q[0] = blend8(w1, 4, w3, 4, 0, 0);
            else if (c07) q[0] = blend8(w4, 5, w0, 3, 0, 0);
            else q[0] = blend8(w4, 4, w1, 2, w3, 2);

            if (c00) q[1] = blend8(w4, 7, w3, 1, 0, 0);
            else if (c08) q[1] = w4;
            else if (c02) q[1] = blend8(w4, 6, w0, 2, 0, 0);
            else if (c09) q[1] = w4;
            else if (c10) q[1] = blend8(w4, 5, w1, 2, w3, 1);
            else if ((p & 8'h0b) == 8'h08) q[1] = blend8(w4, 5, w1, 2, w0, 1);
            else if (c11) q[1] = blend8(w4, 5, w1, 3, 0, 0);
            else if (c04) q[1] = blend8(w1, 6, w4, 2, 0, 0);
            else if (c12) q[1] = blend8(w1, 4, w4, 2, w3, 2);
            else if (c13) q[1] = blend8(w1, 5, w3, 3, 0, 0);
            else if (c05) q[1] = blend8(w4, 7, w3, 1, 0, 0);
            else if ((p & 8'hf3) == 8'h62 || (p & 8'h67) == 8'h66 || (p & 8'h37) == 8'h36 ||
                     (p & 8'hf3) == 8'hf2 || (p & 8'hd7) == 8'hd6 || (p & 8'hd7) == 8'h16 ||
                     (p & 8'h0b) == 8'h02)
                q[1] = blend8(w4, 6, w0, 2, 0, 0);
            else if (c14) q[1] = blend8(w1, 4, w4, 4, 0, 0);
            else q[1] = blend8(w4, 6, w1, 2, 0, 0);

            if (c01) q[2] = blend8(w4, 7, w1, 1, 0, 0);
            else if (c08) q[2] = w4;
            else if (c02) q[2] = blend8(w4, 6, w0, 2, 0, 0);
            else if (c09) q[2] = w4;
            else if (c10) q[2] = blend8(w4, 5, w3, 2, w1, 1);
            else if ((p & 8'h0b) == 8'h02) q[2] = blend8(w4, 5, w3, 2, w0, 1);
            else if (c15) q[2] = blend8(w4, 5, w3, 3, 0, 0);
            else if (c03) q[2] = blend8(w3, 6, w4, 2, 0, 0);
            else if (c13) q[2] = blend8(w3, 4, w4, 2, w1, 2);
            else if (c12) q[2] = blend8(w3, 5, w1, 3, 0, 0);
            else if (c06) q[2] = blend8(w4, 7, w1, 1, 0, 0);
            else if ((p & 8'h0b) == 8'h08 || (p & 8'hf9) == 8'h68 || (p & 8'h6d) == 8'h6c ||
                     (p & 8'h3d) == 8'h3c || (p & 8'hf9) == 8'hf8 || (p & 8'hdd) == 8'hdc ||
                     (p & 8'hdd) == 8'h1c)
                q[2] = blend8(w4, 6, w0, 2, 0, 0);
            else if (c14) q[2] = blend8(w3, 4, w4, 4, 0, 0);
            else q[2] = blend8(w4, 6, w3, 2, 0, 0);

            if (((p & 8'h7f) == 8'h2b || (p & 8'hef) == 8'hab || (p & 8'hbf) == 8'h8f ||
                 (p & 8'h7f) == 8'h0f) && d31) q[3] = w4;
            else if (c02) q[3] = blend8(w4, 7, w0, 1, 0, 0);
            else if (c15) q[3] = blend8(w4, 7, w3, 1, 0, 0);
            else if (c11) q[3] = blend8(w4, 7, w1, 1, 0, 0);
            else if (c10 || c12 || c13) q[3] = blend8(w4, 6, w3, 1, w1, 1);
            else if (c07) q[3] = blend8(w4, 7, w0, 1, 0, 0);
            else q[3] = w4;
        end
    endfunction

    // Mirror the window into each quadrant, run the corner rules, queue 16 pixels
    task automatic predict_block(input window_t win);
        window_t mw;
        logic [23:0] q [4];
        logic [23:0] blk [16];
        logic [7:0] pat;
        int src, r0, c0, r1, c1, nbi;
        pixel_beat_t pb;
        begin
            for (int m = 0; m < 4; m++)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    src = i;
                    if (m & 1) src = (src / 3) * 3 + (2 - src % 3);
                    if (m & 2) src = (2 - src / 3) * 3 + src % 3;
                    mw[i] = win[src];
                end
                pat = '0;
                for (int i = 0; i < 8; i++)
                begin
                    nbi = (i < 4) ? i : i + 1;
                    pat[i] = yuv_differ(mw[4], mw[nbi]);
                end
                corner_rules(mw, pat, q);
                r0 = (m & 2) ? 3 : 0;
                c0 = (m & 1) ? 3 : 0;
                r1 = (m & 2) ? 2 : 1;
                c1 = (m & 1) ? 2 : 1;
                blk[r0 * 4 + c0] = q[0];
                blk[r0 * 4 + c1] = q[1];
                blk[r1 * 4 + c0] = q[2];
                blk[r1 * 4 + c1] = q[3];
            end
            for (int k = 0; k < 16; k++)
            begin
                pb.y = blk[k][23:16];
                pb.u = blk[k][15:8];
                pb.v = blk[k][7:0];
                pb.row = 2'(k >> 2);
                pb.col = 2'(k & 3);
                pb.lst = (k == 15);
                pending_pixels.push_back(pb);
            end
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, compare each beat
    always @(posedge clk)
    begin
        pixel_beat_t exp_pix;
        pixel_beat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_luma, out_u, out_v, sub_row, sub_col, last};
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel beat %h", $realtime, got);
                failed = 1'b1;
            end
            else
            begin
                exp_pix = pending_pixels.pop_front();
                if (got !== exp_pix)
                begin
                    $display("%0t: pixel mismatch expected y=%h u=%h v=%h r=%0d c=%0d l=%b",
                             $realtime, exp_pix.y, exp_pix.u, exp_pix.v, exp_pix.row,
                             exp_pix.col, exp_pix.lst);
                    $display("%0t:                actual   y=%h u=%h v=%h r=%0d c=%0d l=%b",
                             $realtime, got.y, got.u, got.v, got.row, got.col, got.lst);
                    failed = 1'b1;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            out_ready <= 1'b0;
        end
        else if (drain_idle)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: count cycles with no beat accepted on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one register; drop the enable again before the next write
    task automatic write_reg(input logic [hq4x_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            // Out-of-range indexes are dropped by the block
            if (idx == hq4x_pkg::REG_LUMA_THR) thr_y = val;
            else if (idx == hq4x_pkg::REG_U_THR) thr_u = val;
            else if (idx == hq4x_pkg::REG_V_THR) thr_v = val;
            @(posedge clk);
        end
    endtask

    // Hold until every pixel has drained, then let the pipeline settle
    task automatic wait_drained();
        begin
            while (pending_pixels.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Offer one window; hold valid and payload until the beat is accepted
    task automatic send_window(input window_t win, input bit allow_gap);
        begin
            if (allow_gap && !drain_idle && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            in_valid <= 1'b1;
            for (int i = 0; i < 9; i++)
                win_pix[i] <= win[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_block(win);
        end
    endtask

    function automatic logic [23:0] near_pix(logic [23:0] base, int spread);
        logic [23:0] r;
        int t;
        begin
            for (int s = 0; s < 24; s += 8)
            begin
                t = int'(base[s +: 8]) + $urandom_range(0, 2 * spread) - spread;
                if (t < 0) t = 0;
                if (t > 255) t = 255;
                r[s +: 8] = 8'(t);
            end
            return r;
        end
    endfunction

    // Random window: mostly two-tone edge shapes with noise, some pixels fully random
    function automatic window_t random_window();
        window_t w;
        logic [23:0] ca, cb;
        logic [8:0] shape;
        int spread;
        begin
            ca = 24'($urandom);
            cb = 24'($urandom);
            shape = 9'($urandom);
            spread = $urandom_range(0, 12);
            for (int i = 0; i < 9; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    w[i] = 24'($urandom);
                else
                    w[i] = near_pix(shape[i] ? cb : ca, spread);
            end
            return w;
        end
    endfunction

    // Directed windows: solid extremes, single-pixel and edge shapes, all-differ
    localparam int N_DIRECTED = 14;
    localparam logic [23:0] DIRECTED_WIN [N_DIRECTED][9] = '{
        '{default: 24'h000000},
        '{default: 24'hffffff},
        '{24'h000000, 24'hffffff, 24'h000000, 24'hffffff, 24'h000000,
          24'hffffff, 24'h000000, 24'hffffff, 24'h000000},
        '{24'hffffff, 24'h000000, 24'hffffff, 24'h000000, 24'hffffff,
          24'h000000, 24'hffffff, 24'h000000, 24'hffffff},
        '{24'h101010, 24'h101010, 24'h101010, 24'h101010, 24'hf0f0f0,
          24'h101010, 24'h101010, 24'h101010, 24'h101010},
        '{24'hff0000, 24'hff0000, 24'hff0000, 24'h00ff00, 24'h00ff00,
          24'h00ff00, 24'h0000ff, 24'h0000ff, 24'h0000ff},
        '{24'h202020, 24'h202020, 24'hc0c0c0, 24'h202020, 24'hc0c0c0,
          24'hc0c0c0, 24'hc0c0c0, 24'hc0c0c0, 24'hc0c0c0},
        '{24'hc0c0c0, 24'h202020, 24'h202020, 24'hc0c0c0, 24'hc0c0c0,
          24'h202020, 24'hc0c0c0, 24'hc0c0c0, 24'hc0c0c0},
        '{24'h808080, 24'h000000, 24'h808080, 24'h000000, 24'h808080,
          24'h000000, 24'h808080, 24'h000000, 24'h808080},
        '{24'h123456, 24'h654321, 24'habcdef, 24'hfedcba, 24'h55aa55,
          24'haa55aa, 24'h0f0f0f, 24'hf0f0f0, 24'h7f807f},
        // Luma differences exactly at the reset luma threshold, then one past it
        '{24'h807f7f, 24'h807f7f, 24'h807f7f, 24'h807f7f, 24'h504f4f,
          24'h807f7f, 24'h807f7f, 24'h807f7f, 24'h807f7f},
        '{24'h817f7f, 24'h50777f, 24'h504f56, 24'h817f7f, 24'h504f4f,
          24'h504f4f, 24'h504f4f, 24'h504f4f, 24'h504f4f},
        '{24'h000000, 24'h000000, 24'h000000, 24'hffffff, 24'hffffff,
          24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff},
        '{24'haaaaaa, 24'h555555, 24'hffffff, 24'h000000, 24'haaaaaa,
          24'h555555, 24'hffffff, 24'h000000, 24'haaaaaa}
    };

    // Solid black windows have an obvious answer: every output pixel is zero
    initial
    begin
        window_t win;
        int n_random;
        pixel_beat_t zero_pix;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset thresholds
        for (int d = 0; d < N_DIRECTED; d++)
        begin
            for (int i = 0; i < 9; i++)
                win[i] = DIRECTED_WIN[d][i];
            send_window(win, 1'b1);
            if (d == 0)
            begin
                // Check the typed-in answer against the last queued predicted pixel
                zero_pix = pending_pixels[pending_pixels.size() - 1];
                if (zero_pix.y != 0 || zero_pix.u != 0 || zero_pix.v != 0 || !zero_pix.lst)
                begin
                    $display("%0t: black window expected 000000 last=1, predicted %h",
                             $realtime, zero_pix);
                    failed = 1'b1;
                end
            end
        end
        in_valid <= 1'b0;

        // Long receiver hold-off while windows keep coming: fills the job queue
        wait_drained();
        long_hold = 200;
        for (int n = 0; n < 6; n++)
            send_window(random_window(), 1'b0);
        in_valid <= 1'b0;
        wait_drained();

        // Random phases, each under a different threshold setting
        n_random = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(hq4x_pkg::REG_LUMA_THR, THR_SET[ph][0]);
            write_reg(hq4x_pkg::REG_U_THR, THR_SET[ph][1]);
            write_reg(hq4x_pkg::REG_V_THR, THR_SET[ph][2]);
            // Unused index: must be ignored
            write_reg(REG_UNUSED, 8'($urandom));
            if (ph == 4)
                drain_idle = 1'b1;
            for (int n = 0; n < 18; n++)
                send_window(random_window(), 1'b1);
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && pending_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
